@@ rtl/sfrlw_pkg.sv @@
// Shared types, widths and constants of the serial frame receiver.
package sfrlw_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 7;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Frame bytes 1..8 are the only stored bytes that reach a result.
	localparam int STORE_LAST = 8;

	localparam int QDEPTH = 4;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);

	localparam int MAX_FRAME_DEF = 32;

	localparam logic [LEN_W-1:0] LEN_FLOOR = LEN_W'(4);

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'h42;
	localparam logic [LEN_W-1:0]  MIN_RST    = LEN_W'(4);
	localparam logic [LEN_W-1:0]  MAX_RST    = LEN_W'(32);
	localparam logic [BYTE_W-1:0] CTRL_RST   = 8'h01;
	localparam logic [CNT_W-1:0]  DROP_RST   = CNT_W'(3000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER    = 3'd0,
		REG_MIN_LEN   = 3'd1,
		REG_MAX_LEN   = 3'd2,
		REG_CTRL_ADDR = 3'd3,
		REG_DROP_LIM  = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		EVT_FRAME = 1'b0,
		EVT_LOST  = 1'b1
	} evt_kind_t;

	typedef enum logic {
		REC_TICK  = 1'b0,
		REC_FRAME = 1'b1
	} rec_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header;
		logic [LEN_W-1:0]  min_len;
		logic [LEN_W-1:0]  max_len;
		logic [BYTE_W-1:0] ctrl_addr;
		logic [CNT_W-1:0]  drop_limit;
	} cfg_t;

	// One queue entry: a tick, or a frame that passed its checksum.
	typedef struct packed {
		rec_kind_t         kind;
		logic [BYTE_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [31:0]       word;
		logic [15:0]       half;
		logic              is_ctrl;
	} rec_t;

	typedef struct packed {
		logic link_up;
		logic pop;
	} back_st_t;

endpackage

@@ rtl/sfrlw_channels.sv @@
// Handshake channels: received items, result items and register writes.
interface sfrlw_rx_if import sfrlw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface sfrlw_evt_if import sfrlw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              event_kind;
	logic [BYTE_W-1:0] frame_address;
	logic [LEN_W-1:0]  frame_length;
	logic [31:0]       payload_word;
	logic [15:0]       payload_half;
	logic              is_control;
	logic              first_connect;

	modport source (output valid, output event_kind, output frame_address,
		output frame_length, output payload_word, output payload_half,
		output is_control, output first_connect, input ready);
	modport sink (input valid, input event_kind, input frame_address,
		input frame_length, input payload_word, input payload_half,
		input is_control, input first_connect, output ready);
endinterface

interface sfrlw_cfg_if import sfrlw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/sfrlw_front.sv @@
// Frame parser: takes bytes and ticks, checks frames, queues ticks and good frames.
module sfrlw_front import sfrlw_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sfrlw_rx_if.sink   rx,
	input  cfg_t       cfg,
	input  logic       q_full,
	output logic       q_push,
	output rec_t       q_rec
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

	logic [LEN_W-1:0]  mn, mx;
	logic [LEN_W-1:0]  bi_q, bi_n;
	logic [LEN_W-1:0]  dl_q, dl_n;
	logic              in_frame_q, in_frame_n;
	logic [BYTE_W-1:0] sum_q, sum_n;
	logic [BYTE_W-1:0] chk_q, chk_n;
	logic [BYTE_W-1:0] st_q [1:STORE_LAST];
	logic [BYTE_W-1:0] st_n [1:STORE_LAST];
	logic              accept, is_byte, wr_en, done, good;
	logic [LEN_W-1:0]  wr_idx;
	logic [BYTE_W-1:0] b;

	// length bounds as the parser sees them
	always_comb begin
		mn = (cfg.min_len < LEN_FLOOR) ? LEN_FLOOR : cfg.min_len;
		if (cfg.max_len < LEN_FLOOR) begin
			mx = LEN_FLOOR;
		end else if (cfg.max_len > MAX_LEN) begin
			mx = MAX_LEN;
		end else begin
			mx = cfg.max_len;
		end
	end

	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign is_byte  = accept && !rx.action;
	assign b        = rx.rx_byte;

	always_comb begin
		bi_n       = bi_q;
		dl_n       = dl_q;
		in_frame_n = in_frame_q;
		sum_n      = sum_q;
		chk_n      = chk_q;
		wr_en      = 1'b0;
		wr_idx     = bi_q;
		if (is_byte) begin
			priority if (b == cfg.header && !in_frame_q) begin
				in_frame_n = 1'b1;
				dl_n       = mn;
				bi_n       = LEN_W'(1);
				sum_n      = b;
			end else if (bi_q == LEN_W'(2)) begin
				wr_en  = 1'b1;
				wr_idx = LEN_W'(2);
				bi_n   = LEN_W'(3);
				sum_n  = sum_q + b;
				if (b > {1'b0, mx} || b < {1'b0, mn}) begin
					dl_n       = mn;
					bi_n       = '0;
					in_frame_n = 1'b0;
				end else begin
					dl_n = b[LEN_W-1:0];
				end
			end else if (in_frame_q && bi_q < mx) begin
				wr_en = 1'b1;
				bi_n  = bi_q + LEN_W'(1);
				// bytes before the check byte sum up; the check byte is kept aside
				if (bi_n < dl_q) begin
					sum_n = sum_q + b;
				end else if (bi_n == dl_q) begin
					chk_n = b;
				end
			end else begin
				// outside a frame, or past the maximum: the byte is dropped
			end
		end
		done = is_byte && (bi_n >= mx || bi_n >= dl_n) && bi_n > mn;
		good = done && (sum_n == chk_n);
		if (done) begin
			bi_n       = '0;
			in_frame_n = 1'b0;
		end
	end

	always_comb begin
		st_n = st_q;
		for (int k = 1; k <= STORE_LAST; k++) begin
			if (wr_en && wr_idx == LEN_W'(k)) begin
				st_n[k] = b;
			end
		end
	end

	always_comb begin
		q_push = accept && (rx.action || good);
		if (rx.action) begin
			q_rec = '{kind: REC_TICK, addr: '0, len: '0, word: '0, half: '0,
				is_ctrl: 1'b0};
		end else begin
			q_rec = '{kind: REC_FRAME, addr: st_n[1], len: st_n[2][LEN_W-1:0],
				word: {st_n[6], st_n[5], st_n[4], st_n[3]},
				half: {st_n[8], st_n[7]},
				is_ctrl: (st_n[1] == cfg.ctrl_addr)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q       <= '0;
			dl_q       <= MIN_RST;
			in_frame_q <= 1'b0;
		end else begin
			bi_q       <= bi_n;
			dl_q       <= dl_n;
			in_frame_q <= in_frame_n;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_n;
		chk_q <= chk_n;
		st_q  <= st_n;
	end

endmodule

@@ rtl/sfrlw_queue.sv @@
// Short queue of ticks and good frames between parser and link watch.
module sfrlw_queue import sfrlw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output rec_t head,
	output logic empty,
	output logic full
);

	rec_t             ent_q [QDEPTH];
	logic [QA_W-1:0]  wr_q, rd_q;
	logic [QC_W-1:0]  cnt_q;
	logic             do_pop;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == QC_W'(QDEPTH));
	assign head   = ent_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QA_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QA_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + QC_W'(1);
				2'b01:   cnt_q <= cnt_q - QC_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_rec;
		end
	end

endmodule

@@ rtl/sfrlw_back.sv @@
// Link watch: silence counting, link state and the result register.
module sfrlw_back import sfrlw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  rec_t        rec,
	input  logic        q_empty,
	output back_st_t    st,
	sfrlw_evt_if.source evt
);

	logic              link_q;
	logic [CNT_W-1:0]  silence_q, cnt_inc;
	logic              valid_q, take, is_frame, lost, emit;
	logic              kind_q, ctrl_q, first_q;
	logic [BYTE_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [31:0]       word_q;
	logic [15:0]       half_q;

	assign take     = !q_empty && (!valid_q || evt.ready);
	assign is_frame = (rec.kind == REC_FRAME);
	assign cnt_inc  = (silence_q == '1) ? silence_q : silence_q + CNT_W'(1);
	assign lost     = !is_frame && link_q && (cnt_inc > cfg.drop_limit);
	assign emit     = take && (is_frame || lost);

	assign st.link_up = link_q;
	assign st.pop     = take;

	assign evt.valid         = valid_q;
	assign evt.event_kind    = kind_q;
	assign evt.frame_address = addr_q;
	assign evt.frame_length  = len_q;
	assign evt.payload_word  = word_q;
	assign evt.payload_half  = half_q;
	assign evt.is_control    = ctrl_q;
	assign evt.first_connect = first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q    <= 1'b0;
			silence_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (take) begin
				if (is_frame) begin
					link_q    <= 1'b1;
					silence_q <= '0;
				end else if (link_q) begin
					silence_q <= cnt_inc;
					if (lost) begin
						link_q <= 1'b0;
					end
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (evt.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_frame) begin
				kind_q  <= EVT_FRAME;
				addr_q  <= rec.addr;
				len_q   <= rec.len;
				word_q  <= rec.word;
				half_q  <= rec.half;
				ctrl_q  <= rec.is_ctrl;
				first_q <= !link_q;
			end else begin
				kind_q  <= EVT_LOST;
				addr_q  <= '0;
				len_q   <= '0;
				word_q  <= '0;
				half_q  <= '0;
				ctrl_q  <= 1'b0;
				first_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/serial_frame_receiver_with_link_watch_unit.sv @@
// Top level: register file, parser, queue and link watch of the frame receiver.
//
//  channel | dir | carries                                        | handshake
//  --------+-----+------------------------------------------------+------------
//  rx      | in  | action, rx_byte                                | valid/ready
//  evt     | out | event_kind, frame_address, frame_length,       | valid/ready
//          |     | payload_word, payload_half, is_control,        |
//          |     | first_connect                                  |
//  cfg     | in  | index, data (register write)                   | valid/ready
//
// One item per cycle while the queue has room. The parser checks each byte with
// a running checksum; a good frame or a tick enters a 4-entry queue, and the
// link watch takes an entry a cycle unless evt stalls, into the result register.
// Reset loads the register defaults, drops any partial frame and marks the link
// down; the frame byte store is not cleared. While evt stalls, the queue fills
// and rx.ready falls once it holds 4 entries; ticks take a slot too.
module serial_frame_receiver_with_link_watch_unit import sfrlw_pkg::*; #(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sfrlw_rx_if.sink    rx,
	sfrlw_evt_if.source evt,
	sfrlw_cfg_if.sink   cfg
);

	cfg_t     cfg_q;
	logic     q_push, q_full, q_empty;
	rec_t     q_in, q_head;
	back_st_t bst;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{header: HEADER_RST, min_len: MIN_RST, max_len: MAX_RST,
				ctrl_addr: CTRL_RST, drop_limit: DROP_RST};
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_HEADER:    cfg_q.header     <= cfg.data[BYTE_W-1:0];
				REG_MIN_LEN:   cfg_q.min_len    <= cfg.data[LEN_W-1:0];
				REG_MAX_LEN:   cfg_q.max_len    <= cfg.data[LEN_W-1:0];
				REG_CTRL_ADDR: cfg_q.ctrl_addr  <= cfg.data[BYTE_W-1:0];
				REG_DROP_LIM:  cfg_q.drop_limit <= cfg.data[CNT_W-1:0];
				default:       cfg_q            <= cfg_q;
			endcase
		end
	end

	// front: frame parsing and checksum, one byte a cycle while the queue has room
	sfrlw_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_rec  (q_in)
	);

	// decouples the parser from a stalled result port
	sfrlw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (q_in),
		.pop      (bst.pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// back: link state, silence count, result register
	sfrlw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.rec     (q_head),
		.q_empty (q_empty),
		.st      (bst),
		.evt     (evt)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_drop_reports: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bst.link_up) |-> (evt.valid && evt.event_kind == EVT_LOST))
		else $error("link dropped without a lost item");

	a_connect_reports: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bst.link_up) |-> (evt.valid && evt.event_kind == EVT_FRAME &&
			evt.first_connect))
		else $error("link came up without a first-connect frame item");

	a_lost_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.event_kind == EVT_LOST) |-> (evt.frame_address == '0 &&
			evt.frame_length == '0 && evt.payload_word == '0 &&
			evt.payload_half == '0 && !evt.is_control && !evt.first_connect))
		else $error("lost item carries frame fields");
`endif

endmodule
